FILE: design/prc_pkg.sv
// shared types, widths and codes for the page randomness classifier
// no dependencies; every other design file refers to this package by scoped names
`default_nettype none

package prc_pkg;

   localparam int MAX_PAGE_BYTES = 4096;
   localparam int LEN_W          = 13;
   localparam int SUMSQ_W        = 25;
   localparam int LIMIT_W        = 20;
   localparam int SLACK_W        = 8;
   localparam int BYTE_W         = 8;
   localparam int BINS           = 256;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 20;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = 2;
   localparam int QUEUE_LEVEL_W  = 3;
   localparam int PROD_W         = LIMIT_W + LEN_W;
   localparam int S_W            = SUMSQ_W + 1;
   localparam int THR_W          = PROD_W + 1;
   localparam int LHS_W          = S_W + 8;
   localparam int STEP_W         = 3;

   localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7F;

   localparam logic [LIMIT_W-1:0] RANDOM_LIMIT_RESET = 20'd1000;
   localparam logic [LIMIT_W-1:0] ASCII_LIMIT_RESET  = 20'd5000;
   localparam logic [SLACK_W-1:0] SLACK_RESET        = 8'd5;
   localparam logic [LEN_W-1:0]   MIN_LENGTH_RESET   = 13'd256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RANDOM_LIMIT     = 2'd0,
      CSR_ASCII_BAND_LIMIT = 2'd1,
      CSR_SLACK_MIN_RUN    = 2'd2,
      CSR_MIN_LENGTH       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic             is_random;
      logic             ascii_like;
      logic [LEN_W-1:0] used_length;
   } rsp_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] random_limit;
      logic [LIMIT_W-1:0] ascii_band_limit;
      logic [SLACK_W-1:0] slack_min_run;
      logic [LEN_W-1:0]   min_length;
   } cfg_type;

   // page summary handed from the front to the back
   typedef struct packed {
      logic [LEN_W-1:0]   page_length;
      logic [LEN_W-1:0]   zero_run;
      logic [LEN_W-1:0]   zero_count;
      logic [LEN_W-1:0]   printable_count;
      logic [SUMSQ_W-1:0] square_sum;
   } job_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_LEN,
      B_MUL,
      B_DECIDE
   } back_state_type;

endpackage

`default_nettype wire

FILE: design/prc_front.sv
// front end: byte intake, 256-bin histogram with forwarding, page counters
// depends on prc_pkg; pushes one page summary per last byte into prc_queue
`default_nettype none

module prc_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire prc_pkg::req_type                  req_payload,
   input  wire logic [prc_pkg::QUEUE_LEVEL_W-1:0] queue_level,
   output logic                                   push,
   output prc_pkg::job_type                       push_job
);

   logic [prc_pkg::LEN_W-1:0] hist_mem [prc_pkg::BINS];

   logic                         accept;
   logic                         s1_valid_ff;
   logic [prc_pkg::BYTE_W-1:0]   s1_byte_ff;
   logic                         s1_last_ff;
   logic [prc_pkg::LEN_W-1:0]    rd_data_ff;
   logic [prc_pkg::BINS-1:0]     bin_valid_ff;
   logic                         fwd_valid_ff;
   logic [prc_pkg::BYTE_W-1:0]   fwd_byte_ff;
   logic [prc_pkg::LEN_W-1:0]    fwd_count_ff;

   logic [prc_pkg::LEN_W-1:0]    page_len_ff,  page_len_in;
   logic [prc_pkg::LEN_W-1:0]    zero_run_ff,  zero_run_in;
   logic [prc_pkg::LEN_W-1:0]    zero_cnt_ff,  zero_cnt_in;
   logic [prc_pkg::LEN_W-1:0]    print_cnt_ff, print_cnt_in;
   logic [prc_pkg::SUMSQ_W-1:0]  sumsq_ff,     sumsq_in;

   logic                         take;
   logic                         is_zero;
   logic                         is_print;
   logic [prc_pkg::LEN_W-1:0]    cur_count;
   logic [prc_pkg::LEN_W-1:0]    new_count;
   logic [prc_pkg::QUEUE_LEVEL_W-1:0] need;

   // room for every page already accepted, including one still in stage 1
   assign need      = queue_level + {{(prc_pkg::QUEUE_LEVEL_W-1){1'b0}}, s1_valid_ff & s1_last_ff};
   assign req_stall = (need >= prc_pkg::QUEUE_LEVEL_W'(prc_pkg::QUEUE_DEPTH));
   assign accept    = req_valid & ~req_stall;

   assign take     = s1_valid_ff && (page_len_ff < prc_pkg::LEN_W'(prc_pkg::MAX_PAGE_BYTES));
   assign is_zero  = (s1_byte_ff == '0);
   assign is_print = (s1_byte_ff >= prc_pkg::PRINT_LO) && (s1_byte_ff < prc_pkg::PRINT_HI);

   always_comb begin
      if (fwd_valid_ff && (fwd_byte_ff == s1_byte_ff)) begin
         cur_count = fwd_count_ff;
      end else if (bin_valid_ff[s1_byte_ff]) begin
         cur_count = rd_data_ff;
      end else begin
         cur_count = '0;
      end
   end

   assign new_count = cur_count + 1'b1;

   always_comb begin
      page_len_in  = page_len_ff;
      zero_run_in  = zero_run_ff;
      zero_cnt_in  = zero_cnt_ff;
      print_cnt_in = print_cnt_ff;
      sumsq_in     = sumsq_ff;
      if (take) begin
         page_len_in = page_len_ff + 1'b1;
         if (is_zero) begin
            zero_run_in = zero_run_ff + 1'b1;
            zero_cnt_in = zero_cnt_ff + 1'b1;
         end else begin
            zero_run_in = '0;
            // (c+1)^2 - c^2 = 2c + 1
            sumsq_in = sumsq_ff
                     + {{(prc_pkg::SUMSQ_W-prc_pkg::LEN_W-1){1'b0}}, cur_count, 1'b1};
         end
         if (is_print) begin
            print_cnt_in = print_cnt_ff + 1'b1;
         end
      end
   end

   assign push                     = s1_valid_ff & s1_last_ff;
   assign push_job.page_length     = page_len_in;
   assign push_job.zero_run        = zero_run_in;
   assign push_job.zero_count      = zero_cnt_in;
   assign push_job.printable_count = print_cnt_in;
   assign push_job.square_sum      = sumsq_in;

   // histogram memory, read in the cycle before the update
   always_ff @(posedge clock) begin
      if (take && !s1_last_ff) begin
         hist_mem[s1_byte_ff] <= new_count;
      end
      rd_data_ff <= hist_mem[req_payload.data_byte];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_payload.data_byte;
         s1_last_ff <= req_payload.last_byte;
      end
      if (take) begin
         fwd_byte_ff  <= s1_byte_ff;
         fwd_count_ff <= new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         bin_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
         page_len_ff  <= '0;
         zero_run_ff  <= '0;
         zero_cnt_ff  <= '0;
         print_cnt_ff <= '0;
         sumsq_ff     <= '0;
      end else begin
         s1_valid_ff <= accept;
         if (s1_valid_ff && s1_last_ff) begin
            bin_valid_ff <= '0;
            fwd_valid_ff <= 1'b0;
            page_len_ff  <= '0;
            zero_run_ff  <= '0;
            zero_cnt_ff  <= '0;
            print_cnt_ff <= '0;
            sumsq_ff     <= '0;
         end else begin
            if (take) begin
               bin_valid_ff[s1_byte_ff] <= 1'b1;
               fwd_valid_ff             <= 1'b1;
            end
            page_len_ff  <= page_len_in;
            zero_run_ff  <= zero_run_in;
            zero_cnt_ff  <= zero_cnt_in;
            print_cnt_ff <= print_cnt_in;
            sumsq_ff     <= sumsq_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/prc_queue.sv
// short queue of page summaries between front and back
// depends on prc_pkg; show-ahead head entry
`default_nettype none

module prc_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire prc_pkg::job_type         push_job,
   input  wire logic                     pop,
   output prc_pkg::job_type              head_job,
   output logic [prc_pkg::QUEUE_LEVEL_W-1:0] level
);

   prc_pkg::job_type                   entry_ff [prc_pkg::QUEUE_DEPTH];
   logic [prc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [prc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [prc_pkg::QUEUE_LEVEL_W-1:0]  level_ff;

   assign head_job = entry_ff[rd_ptr_ff];
   assign level    = level_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         priority if (push && !pop) begin
            level_ff <= level_ff + 1'b1;
         end else if (pop && !push) begin
            level_ff <= level_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/prc_back.sv
// back end: slack cut, length floor, poker statistic by cross-multiplication
// depends on prc_pkg; one shared 20x13 multiplier, result held in an output register
`default_nettype none

module prc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire prc_pkg::cfg_type                  cfg,
   input  wire prc_pkg::job_type                  head_job,
   input  wire logic [prc_pkg::QUEUE_LEVEL_W-1:0] queue_level,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output prc_pkg::rsp_type                       rsp_payload
);

   prc_pkg::back_state_type state_ff, state_in;

   prc_pkg::job_type              job_ff;
   logic [prc_pkg::LEN_W-1:0]     used_ff;
   logic [prc_pkg::LEN_W-1:0]     z0_ff;
   logic                          ascii_ff;
   logic [prc_pkg::STEP_W-1:0]    step_ff;
   logic [prc_pkg::PROD_W-1:0]    prod_ff;
   logic [prc_pkg::S_W-1:0]       s_ff;
   logic [prc_pkg::LEN_W*2-1:0]   base_ff;
   logic [prc_pkg::THR_W-1:0]     lo_ff;
   logic [prc_pkg::THR_W-1:0]     hi_ff;
   logic                          rsp_valid_ff;
   prc_pkg::rsp_type              rsp_ff;

   logic                          load_job;
   logic                          load_len;
   logic                          mul_run;
   logic                          load_out;
   logic                          out_free;
   logic                          mul_done;

   logic                          cut;
   logic [prc_pkg::LEN_W-1:0]     used_a, used_b, used_c;
   logic [prc_pkg::LEN_W:0]       print_x2;
   logic [prc_pkg::LIMIT_W-1:0]   mul_a;
   logic [prc_pkg::LEN_W-1:0]     mul_b;
   logic [prc_pkg::LHS_W-1:0]     lhs;
   logic                          rnd;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign mul_done = (step_ff == prc_pkg::STEP_W'(4));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prc_pkg::B_IDLE: begin
            if (queue_level != '0) begin
               state_in = prc_pkg::B_LEN;
            end
         end
         prc_pkg::B_LEN: begin
            state_in = prc_pkg::B_MUL;
         end
         prc_pkg::B_MUL: begin
            if (mul_done) begin
               state_in = prc_pkg::B_DECIDE;
            end
         end
         prc_pkg::B_DECIDE: begin
            if (out_free) begin
               state_in = prc_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = prc_pkg::B_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      load_job = 1'b0;
      load_len = 1'b0;
      mul_run  = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         prc_pkg::B_IDLE:   load_job = (queue_level != '0);
         prc_pkg::B_LEN:    load_len = 1'b1;
         prc_pkg::B_MUL:    mul_run  = 1'b1;
         prc_pkg::B_DECIDE: load_out = out_free;
         default: begin
         end
      endcase
   end

   assign pop = load_job;

   // used length: slack cut, then floor at min_length, never past the page
   assign cut    = (job_ff.zero_run >= {{(prc_pkg::LEN_W-prc_pkg::SLACK_W){1'b0}},
                                        cfg.slack_min_run});
   assign used_a = cut ? (job_ff.page_length - job_ff.zero_run) : job_ff.page_length;
   assign used_b = (used_a < cfg.min_length) ? cfg.min_length : used_a;
   assign used_c = (used_b > job_ff.page_length) ? job_ff.page_length : used_b;
   assign print_x2 = {job_ff.printable_count, 1'b0};

   // shared multiplier operands: z0^2, N^2, random_limit*N, ascii_band_limit*N
   always_comb begin
      mul_b = used_ff;
      unique case (step_ff)
         prc_pkg::STEP_W'(0): begin
            mul_a = {{(prc_pkg::LIMIT_W-prc_pkg::LEN_W){1'b0}}, z0_ff};
            mul_b = z0_ff;
         end
         prc_pkg::STEP_W'(1): mul_a = {{(prc_pkg::LIMIT_W-prc_pkg::LEN_W){1'b0}}, used_ff};
         prc_pkg::STEP_W'(2): mul_a = cfg.random_limit;
         prc_pkg::STEP_W'(3): mul_a = cfg.ascii_band_limit;
         default:             mul_a = '0;
      endcase
   end

   assign lhs = {s_ff, 8'h00};
   assign rnd = (used_ff != '0) &&
                ((prc_pkg::THR_W'(lhs) < lo_ff) ||
                 ((prc_pkg::THR_W'(lhs) > lo_ff) && (prc_pkg::THR_W'(lhs) < hi_ff) && !ascii_ff));

   always_ff @(posedge clock) begin
      if (load_job) begin
         job_ff <= head_job;
      end
      if (load_len) begin
         used_ff  <= used_c;
         z0_ff    <= job_ff.zero_count - (job_ff.page_length - used_c);
         ascii_ff <= ({1'b0, used_c} <= print_x2);
      end
      if (mul_run) begin
         prod_ff <= mul_a * {{(prc_pkg::PROD_W-prc_pkg::LEN_W){1'b0}}, mul_b};
         unique case (step_ff)
            prc_pkg::STEP_W'(1): s_ff <= {1'b0, job_ff.square_sum}
                                        + prc_pkg::S_W'(prod_ff);
            prc_pkg::STEP_W'(2): base_ff <= prod_ff[prc_pkg::LEN_W*2-1:0];
            prc_pkg::STEP_W'(3): lo_ff <= prc_pkg::THR_W'(base_ff) + prc_pkg::THR_W'(prod_ff);
            prc_pkg::STEP_W'(4): hi_ff <= prc_pkg::THR_W'(base_ff) + prc_pkg::THR_W'(prod_ff);
            default: begin
            end
         endcase
      end
      if (load_out) begin
         rsp_ff.is_random   <= rnd;
         rsp_ff.ascii_like  <= ascii_ff;
         rsp_ff.used_length <= used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prc_pkg::B_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mul_run && !mul_done) begin
            step_ff <= step_ff + 1'b1;
         end else begin
            step_ff <= '0;
         end
         priority if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

FILE: design/page_randomness_classifier_top.sv
// top level of the page randomness classifier: configuration registers and
// the front / queue / back split; depends on prc_pkg, prc_front, prc_queue, prc_back
`default_nettype none

// Bytes of a page arrive one per transfer on the req_ channel, the last one
// marked by last_byte. The front takes one byte every cycle unless req_stall
// is raised for a full queue: the histogram update is a read-modify-write on
// a 256 x 13 memory with forwarding of the previous write, so equal bytes
// back to back cost nothing extra. Bytes past 4096 in a page are dropped but
// their last_byte mark still closes the page. Each closed page leaves a
// summary in a four-entry queue; the back picks it up, applies the length
// rules, runs the shared multiplier, decides and gives one rsp_ transfer,
// one page at a time, so short pages run at the back's pace and longer ones
// at one byte per cycle. Histogram bins are cleared at page end through
// per-bin valid flags, so the next page can start in the cycle after its
// predecessor's last byte.
// Configuration writes on the csr_ port take effect at once and should be
// made only while no page is in flight.
module page_randomness_classifier_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire prc_pkg::req_type                  req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output prc_pkg::rsp_type                       rsp_payload,
   input  wire logic                              csr_write_enable,
   input  wire logic [prc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [prc_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   prc_pkg::cfg_type                     cfg_ff;
   prc_pkg::job_type                     push_job;
   prc_pkg::job_type                     head_job;
   logic                                 queue_push;
   logic                                 queue_pop;
   logic [prc_pkg::QUEUE_LEVEL_W-1:0]    queue_level;

   // configuration registers, write only
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.random_limit     <= prc_pkg::RANDOM_LIMIT_RESET;
         cfg_ff.ascii_band_limit <= prc_pkg::ASCII_LIMIT_RESET;
         cfg_ff.slack_min_run    <= prc_pkg::SLACK_RESET;
         cfg_ff.min_length       <= prc_pkg::MIN_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (prc_pkg::csr_index_type'(csr_index))
            prc_pkg::CSR_RANDOM_LIMIT:
               cfg_ff.random_limit <= csr_write_data[prc_pkg::LIMIT_W-1:0];
            prc_pkg::CSR_ASCII_BAND_LIMIT:
               cfg_ff.ascii_band_limit <= csr_write_data[prc_pkg::LIMIT_W-1:0];
            prc_pkg::CSR_SLACK_MIN_RUN:
               cfg_ff.slack_min_run <= csr_write_data[prc_pkg::SLACK_W-1:0];
            prc_pkg::CSR_MIN_LENGTH:
               cfg_ff.min_length <= csr_write_data[prc_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: one byte per transfer, histogram and running counters
   prc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_level (queue_level),
      .push        (queue_push),
      .push_job    (push_job)
   );

   // page summaries waiting for the back
   prc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_job (push_job),
      .pop      (queue_pop),
      .head_job (head_job),
      .level    (queue_level)
   );

   // back: length rules and the statistic, one page at a time
   prc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_job    (head_job),
      .queue_level (queue_level),
      .pop         (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
